// ----- rtl/core/cai_pkg.sv -----
// ----------------------------------------------------------------------------
// cai_pkg: shared types and constants of the circular arc interpolator
// Fixed-point formats, CORDIC arctangent table and control structs used
// between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package cai_pkg;

  // Sizing of the iterative units
  localparam int CORDIC_ITERS    = 32;
  localparam int CORDIC_TAB_LEN  = 40;
  localparam int CORDIC_N        = (CORDIC_ITERS > CORDIC_TAB_LEN) ? CORDIC_TAB_LEN
                                                                   : CORDIC_ITERS;
  localparam int STEP_COUNT_BITS = 24;
  localparam int ITW             = 6;   // iteration counter width
  localparam int XW              = 48;  // CORDIC x/y datapath width
  localparam int ZW              = 36;  // CORDIC angle accumulator width

  // Port payload widths
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 96;

  // Opcodes carried in the input tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_AXIS_TOL = 1'b0;
  localparam logic CFG_CHORD    = 1'b1;

  // Angles as turn fractions, 33 bits so a full turn is representable
  localparam logic [32:0] TURN_Q1   = 33'h040000000;
  localparam logic [32:0] TURN_HALF = 33'h080000000;
  localparam logic [32:0] TURN_Q3   = 33'h0C0000000;
  localparam logic [32:0] TURN_FULL = 33'h100000000;

  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
  localparam logic [31:0] CORDIC_K_Q30 = 32'd652032874;

  localparam logic [32:0] STEP_MAX = 33'((64'd1 << STEP_COUNT_BITS) - 64'd1);

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cordic_mode_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // atan(2^-i) in turn fractions
  function automatic logic [31:0] atan_entry(input logic [ITW-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      6'd0:  v = 32'h20000000;
      6'd1:  v = 32'h12E4051E;
      6'd2:  v = 32'h09FB385B;
      6'd3:  v = 32'h051111D4;
      6'd4:  v = 32'h028B0D43;
      6'd5:  v = 32'h0145D7E1;
      6'd6:  v = 32'h00A2F61E;
      6'd7:  v = 32'h00517C55;
      6'd8:  v = 32'h0028BE53;
      6'd9:  v = 32'h00145F2F;
      6'd10: v = 32'h000A2F98;
      6'd11: v = 32'h000517CC;
      6'd12: v = 32'h00028BE6;
      6'd13: v = 32'h000145F3;
      6'd14: v = 32'h0000A2FA;
      6'd15: v = 32'h0000517D;
      6'd16: v = 32'h000028BE;
      6'd17: v = 32'h0000145F;
      6'd18: v = 32'h00000A30;
      6'd19: v = 32'h00000518;
      6'd20: v = 32'h0000028C;
      6'd21: v = 32'h00000146;
      6'd22: v = 32'h000000A3;
      6'd23: v = 32'h00000051;
      6'd24: v = 32'h00000029;
      6'd25: v = 32'h00000014;
      6'd26: v = 32'h0000000A;
      6'd27: v = 32'h00000005;
      6'd28: v = 32'h00000003;
      6'd29: v = 32'h00000001;
      6'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/cai_cordic.sv -----
// ----------------------------------------------------------------------------
// cai_cordic: shared CORDIC engine
// One micro-rotation per cycle, rotation mode for sin/cos and vectoring mode
// for arctangent. Done pulses for one cycle after the last iteration.
// ----------------------------------------------------------------------------
module cai_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cai_pkg::cordic_ctl_t          ctl,
  input  logic signed [cai_pkg::XW-1:0] x_in,
  input  logic signed [cai_pkg::XW-1:0] y_in,
  input  logic signed [cai_pkg::ZW-1:0] z_in,
  output cai_pkg::unit_sts_t            sts,
  output logic signed [cai_pkg::XW-1:0] x_out,
  output logic signed [cai_pkg::ZW-1:0] z_out,
  output logic signed [cai_pkg::XW-1:0] y_out
);

  logic signed [cai_pkg::XW-1:0]  x_r, y_r, x_nxt, y_nxt, sx, sy;
  logic signed [cai_pkg::ZW-1:0]  z_r, z_nxt, tab;
  logic [cai_pkg::ITW-1:0]        it_r;
  logic                           busy_r, done_r, pos;
  cai_pkg::cordic_mode_t          mode_r;

  // One micro-rotation
  always_comb begin
    sx  = x_r >>> it_r;
    sy  = y_r >>> it_r;
    tab = signed'(cai_pkg::ZW'(cai_pkg::atan_entry(it_r)));
    pos = (mode_r == cai_pkg::CM_ROTATE) ? !z_r[cai_pkg::ZW-1] : (y_r <= 0);
    x_nxt = pos ? (x_r - sy) : (x_r + sy);
    y_nxt = pos ? (y_r + sx) : (y_r - sx);
    z_nxt = pos ? (z_r - tab) : (z_r + tab);
  end

  // Load, iterate, flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else if (ctl.start) begin
      x_r    <= x_in;
      y_r    <= y_in;
      z_r    <= z_in;
      mode_r <= ctl.mode;
      it_r   <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      it_r <= it_r + 1'b1;
      if (it_r == cai_pkg::ITW'(cai_pkg::CORDIC_N - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;

endmodule

// ----- rtl/core/cai_div.sv -----
// ----------------------------------------------------------------------------
// cai_div: restoring divider
// 64-bit dividend over 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cai_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        dividend,
  input  logic [31:0]        divisor,
  output cai_pkg::unit_sts_t sts,
  output logic [63:0]        quotient
);

  logic [63:0] dvd_r;
  logic [31:0] rem_r, dvs_r;
  logic [32:0] trial, diff;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r, ge;

  // Trial subtract of the next remainder
  always_comb begin
    trial = {rem_r, dvd_r[63]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      dvd_r <= {dvd_r[62:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r;

endmodule

// ----- rtl/core/circular_arc_interpolator.sv -----
// ----------------------------------------------------------------------------
// circular_arc_interpolator: G02/G03 arc interpolation in the first plane
// A start request sets up angles, radius, angular step and step count; each step
// request with steps left advances the angle and accumulates both axis offsets.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | in_tdata 200b, in_tuser op
//   out_    | out | out_tvalid/out_tready| out_tdata 96b
//   cfg_    | in  | cfg_valid/cfg_ready  | cfg_index 1b, cfg_data 31b
//
// Start request: a square root, up to two divisions and two angle evaluations
// (an on-axis point is placed directly, a general point is normalized and
// then takes a CORDIC vectoring pass). Step request: two CORDIC sin/cos
// passes. The CORDIC engine and divider are shared; in_tready is high only
// while idle. A finished result waits in the output register, and a new
// request is taken meanwhile. rst_n is synchronous; config is always ready.
// ----------------------------------------------------------------------------
module circular_arc_interpolator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // start_first, start_second, end_first, end_second, centre_off_first,
  // centre_off_second (32b each), clockwise (1b), zero fill
  input  logic [cai_pkg::IN_DATA_W-1:0]   in_tdata,
  // op
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // offset_first (32b), offset_second (32b), steps_remaining (24b),
  // stepped (1b), zero fill
  output logic [cai_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [0:0]                      cfg_index,
  input  logic [30:0]                     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_I, S_SQ_J, S_SQ_SUM, S_SQRT, S_MULC, S_DIVS, S_DIVS_W,
    S_ANG_SEL, S_NORM, S_ATAN, S_QUAD, S_SWEEP, S_SWDIV, S_DIVC_W, S_COMMIT,
    S_SC0, S_SC1, S_MUL_X, S_MUL_Y, S_ACC_Y, S_OUT
  } state_t;

  localparam int SCB = cai_pkg::STEP_COUNT_BITS;

  state_t state_r;

  // Configuration
  logic [30:0] tol_r, chord_r;

  // Arc state
  logic [31:0]             angle_now_r, angle_step_r, radius_r;
  logic [SCB-1:0]          steps_left_r;
  logic signed [31:0]      acc_first_r, acc_second_r;
  logic                    dir_cw_r, stepped_r;

  // Start setup working registers
  logic signed [31:0]      ci_r, cj_r;
  logic signed [33:0]      ex_r, ey_r;
  logic                    cw_r, pt_sel_r;
  logic [63:0]             rt_v_r, rt_res_r, rt_bit_r, sq_r;
  logic [63:0]             rt_sum;
  logic                    rt_ge;
  logic [31:0]             stp_r;
  logic [40:0]             nx_r, ny_r;
  logic [30:0]             t_r;
  logic [32:0]             a0_r, a1_r;
  logic [33:0]             sweep_r;
  logic [SCB-1:0]          cnt_r;

  // Step working registers
  logic [31:0]             nxt_ang_r;
  logic                    flip_r;
  logic signed [33:0]      c0_r, s0_r, dc_r, ds_r;

  // Shared multiplier
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      mul_p_r;

  // Units
  cai_pkg::cordic_ctl_t           cor_ctl;
  cai_pkg::unit_sts_t             cor_sts, div_sts;
  logic signed [cai_pkg::XW-1:0]  cor_x_in, cor_y_in, cor_x, cor_y;
  logic signed [cai_pkg::ZW-1:0]  cor_z_in, cor_z;
  logic                           div_start;
  logic [63:0]                    div_dvd, div_q;
  logic [31:0]                    div_dvs;

  // Input fields and misc combinational terms
  logic                    in_acc;
  logic signed [31:0]      f_sf, f_ss, f_ef, f_es, f_ci, f_cj;
  logic [31:0]             ai, aj, rot_a, rot_z;
  logic signed [33:0]      px, py, px_abs, py_abs;
  logic [32:0]             ax, ay, axis_ang, quad_ang;
  logic                    py_pos, px_pos;
  logic signed [34:0]      sw;
  logic                    sw_wrap;
  logic signed [33:0]      cor_c, cor_s;
  logic [32:0]             sl_ext;
  logic [23:0]             steps_out;

  // Add a rounded radius product to an accumulator, saturating
  function automatic logic signed [31:0] acc_add(input logic signed [31:0] acc,
                                                  input logic signed [65:0] p);
    logic signed [65:0] rp, sh;
    logic signed [36:0] sum;
    rp  = p + 66'sd536870912;
    sh  = rp >>> 30;
    sum = 37'(acc) + sh[36:0];
    if (sum > 37'sd2147483647) return 32'sh7FFFFFFF;
    else if (sum < -37'sd2147483648) return 32'sh80000000;
    else return sum[31:0];
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign f_sf = in_tdata[31:0];
  assign f_ss = in_tdata[63:32];
  assign f_ef = in_tdata[95:64];
  assign f_es = in_tdata[127:96];
  assign f_ci = in_tdata[159:128];
  assign f_cj = in_tdata[191:160];

  // Magnitudes of the centre offset
  assign ai = ci_r[31] ? (~ci_r + 32'd1) : ci_r;
  assign aj = cj_r[31] ? (~cj_r + 32'd1) : cj_r;

  // Point under angle evaluation: start relative to centre, then end
  always_comb begin
    if (!pt_sel_r) begin
      px = -34'(ci_r);
      py = -34'(cj_r);
    end else begin
      px = ex_r;
      py = ey_r;
    end
    px_abs = px[33] ? -px : px;
    py_abs = py[33] ? -py : py;
    ax     = px_abs[32:0];
    ay     = py_abs[32:0];
    px_pos = !px[33] && (px != 34'sd0);
    py_pos = !py[33] && (py != 34'sd0);
    // on-axis angle
    if (ax < 33'(tol_r)) axis_ang = py_pos ? cai_pkg::TURN_Q1 : cai_pkg::TURN_Q3;
    else if (px_pos)     axis_ang = (pt_sel_r && !cw_r) ? cai_pkg::TURN_FULL : 33'd0;
    else                 axis_ang = cai_pkg::TURN_HALF;
    // quadrant fix-up of the first-quadrant arctangent
    if (py_pos) quad_ang = px[33] ? (cai_pkg::TURN_HALF - 33'(t_r)) : 33'(t_r);
    else        quad_ang = px[33] ? (cai_pkg::TURN_HALF + 33'(t_r))
                                  : (cai_pkg::TURN_FULL - 33'(t_r));
  end

  // Square root step
  assign rt_sum = rt_res_r + rt_bit_r;
  assign rt_ge  = (rt_v_r >= rt_sum);

  // Sweep between start and end angle
  always_comb begin
    sw      = cw_r ? (35'(a0_r) - 35'(a1_r)) : (35'(a1_r) - 35'(a0_r));
    sw_wrap = sw[34] || ({sw[32:0], 1'b0} < 34'(stp_r));
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ_I: begin
        mul_a = signed'({1'b0, ai});
        mul_b = signed'({1'b0, ai});
      end
      S_SQ_J: begin
        mul_a = signed'({1'b0, aj});
        mul_b = signed'({1'b0, aj});
      end
      S_MULC: begin
        mul_a = signed'(33'(chord_r));
        mul_b = signed'(33'(cai_pkg::TURN_PER_RAD));
      end
      S_MUL_X: begin
        mul_a = signed'({1'b0, radius_r});
        mul_b = dc_r[32:0];
      end
      S_MUL_Y: begin
        mul_a = signed'({1'b0, radius_r});
        mul_b = ds_r[32:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // CORDIC operands and launch
  always_comb begin
    rot_a   = (state_r == S_SC0) ? nxt_ang_r : angle_now_r;
    rot_z   = (rot_a[31] ^ rot_a[30]) ? (rot_a ^ 32'h80000000) : rot_a;
    cor_ctl.start = ((state_r == S_NORM) && (nx_r[40] || ny_r[40])) ||
                    (in_acc && (in_tuser[0] == cai_pkg::OP_STEP) &&
                     (steps_left_r != '0)) ||
                    ((state_r == S_SC0) && cor_sts.done);
    if (state_r == S_NORM) begin
      cor_ctl.mode = cai_pkg::CM_VECTOR;
      cor_x_in     = signed'(cai_pkg::XW'(nx_r));
      cor_y_in     = signed'(cai_pkg::XW'(ny_r));
      cor_z_in     = '0;
    end else begin
      cor_ctl.mode = cai_pkg::CM_ROTATE;
      cor_x_in     = signed'(cai_pkg::XW'(cai_pkg::CORDIC_K_Q30));
      cor_y_in     = '0;
      cor_z_in     = cai_pkg::ZW'(signed'(rot_z));
    end
    cor_c = flip_r ? -cor_x[33:0] : cor_x[33:0];
    cor_s = flip_r ? -cor_y[33:0] : cor_y[33:0];
  end

  // Divider operands and launch
  always_comb begin
    div_start = ((state_r == S_DIVS) && (radius_r != 32'd0)) ||
                ((state_r == S_SWDIV) && (stp_r != 32'd0));
    if (state_r == S_DIVS) begin
      div_dvd = mul_p_r[63:0];
      div_dvs = radius_r;
    end else begin
      div_dvd = 64'(sweep_r);
      div_dvs = stp_r;
    end
  end

  cai_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cor_ctl),
    .x_in  (cor_x_in),
    .y_in  (cor_y_in),
    .z_in  (cor_z_in),
    .sts   (cor_sts),
    .x_out (cor_x),
    .z_out (cor_z),
    .y_out (cor_y)
  );

  cai_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Result fields
  assign sl_ext    = 33'(steps_left_r);
  assign steps_out = (sl_ext > 33'h0FFFFFF) ? 24'hFFFFFF : sl_ext[23:0];

  // Sequencer, arc state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tol_r        <= 31'd66;
      chord_r      <= 31'd6554;
      angle_now_r  <= '0;
      angle_step_r <= '0;
      radius_r     <= '0;
      steps_left_r <= '0;
      acc_first_r  <= '0;
      acc_second_r <= '0;
      dir_cw_r     <= 1'b0;
      stepped_r    <= 1'b0;
      out_tvalid   <= 1'b0;
    end else begin
      // write configuration
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index[0])
          cai_pkg::CFG_AXIS_TOL: tol_r   <= cfg_data;
          cai_pkg::CFG_CHORD:    chord_r <= cfg_data;
        endcase
      end
      // drop a taken result unless a new one loads in its place
      if (out_tvalid && out_tready && (state_r != S_OUT)) out_tvalid <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser[0] == cai_pkg::OP_START) begin
              ci_r     <= f_ci;
              cj_r     <= f_cj;
              ex_r     <= 34'(f_ef) - 34'(f_sf) - 34'(f_ci);
              ey_r     <= 34'(f_es) - 34'(f_ss) - 34'(f_cj);
              cw_r     <= in_tdata[192];
              pt_sel_r <= 1'b0;
              state_r  <= S_SQ_I;
            end else if (steps_left_r == '0) begin
              stepped_r <= 1'b0;
              state_r   <= S_OUT;
            end else begin
              nxt_ang_r <= dir_cw_r ? (angle_now_r - angle_step_r)
                                    : (angle_now_r + angle_step_r);
              flip_r    <= angle_now_r[31] ^ angle_now_r[30];
              state_r   <= S_SC0;
            end
          end
        end
        S_SQ_I: state_r <= S_SQ_J;
        S_SQ_J: begin
          sq_r    <= mul_p_r[63:0];
          state_r <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          rt_v_r   <= sq_r + mul_p_r[63:0];
          rt_res_r <= '0;
          rt_bit_r <= 64'd1 << 62;
          state_r  <= S_SQRT;
        end
        // one radius bit per cycle
        S_SQRT: begin
          if (rt_ge) begin
            rt_v_r   <= rt_v_r - rt_sum;
            rt_res_r <= (rt_res_r >> 1) + rt_bit_r;
          end else begin
            rt_res_r <= rt_res_r >> 1;
          end
          rt_bit_r <= rt_bit_r >> 2;
          if (rt_bit_r == 64'd1) begin
            radius_r <= rt_ge ? 32'((rt_res_r >> 1) + rt_bit_r) : 32'(rt_res_r >> 1);
            state_r  <= S_MULC;
          end
        end
        S_MULC: state_r <= S_DIVS;
        S_DIVS: begin
          if (radius_r == 32'd0) begin
            stp_r   <= '1;
            state_r <= S_ANG_SEL;
          end else begin
            state_r <= S_DIVS_W;
          end
        end
        S_DIVS_W: begin
          if (div_sts.done) begin
            stp_r   <= (div_q[63:32] != 32'd0) ? '1 : div_q[31:0];
            state_r <= S_ANG_SEL;
          end
        end
        // classify the point: on an axis, at the centre, or general
        S_ANG_SEL: begin
          if ((ax < 33'(tol_r)) || (ay < 33'(tol_r))) begin
            if (!pt_sel_r) a0_r <= axis_ang;
            else           a1_r <= axis_ang;
            pt_sel_r <= 1'b1;
            state_r  <= pt_sel_r ? S_SWEEP : S_ANG_SEL;
          end else if ((ax == 33'd0) && (ay == 33'd0)) begin
            t_r     <= '0;
            state_r <= S_QUAD;
          end else begin
            nx_r    <= 41'(ax);
            ny_r    <= 41'(ay);
            state_r <= S_NORM;
          end
        end
        // normalize one bit a cycle, then launch vectoring
        S_NORM: begin
          if (nx_r[40] || ny_r[40]) begin
            state_r <= S_ATAN;
          end else begin
            nx_r <= nx_r << 1;
            ny_r <= ny_r << 1;
          end
        end
        S_ATAN: begin
          if (cor_sts.done) begin
            if (cor_z[cai_pkg::ZW-1])                   t_r <= '0;
            else if (cor_z > cai_pkg::ZW'(33'h40000000)) t_r <= 31'h40000000;
            else                                        t_r <= cor_z[30:0];
            state_r <= S_QUAD;
          end
        end
        S_QUAD: begin
          if (!pt_sel_r) a0_r <= quad_ang;
          else           a1_r <= quad_ang;
          pt_sel_r <= 1'b1;
          state_r  <= pt_sel_r ? S_SWEEP : S_ANG_SEL;
        end
        S_SWEEP: begin
          sweep_r <= sw_wrap ? 34'(sw + 35'sh100000000) : sw[33:0];
          state_r <= S_SWDIV;
        end
        S_SWDIV: begin
          if (stp_r == 32'd0) begin
            cnt_r   <= SCB'(cai_pkg::STEP_MAX);
            state_r <= S_COMMIT;
          end else begin
            state_r <= S_DIVC_W;
          end
        end
        S_DIVC_W: begin
          if (div_sts.done) begin
            cnt_r   <= (div_q >= 64'(cai_pkg::STEP_MAX)) ? SCB'(cai_pkg::STEP_MAX)
                                                       : SCB'(div_q + 64'd1);
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          angle_now_r  <= a0_r[31:0];
          angle_step_r <= stp_r;
          steps_left_r <= cnt_r;
          dir_cw_r     <= cw_r;
          acc_first_r  <= '0;
          acc_second_r <= '0;
          stepped_r    <= 1'b0;
          state_r      <= S_OUT;
        end
        // sin/cos of the current angle, then of the next one
        S_SC0: begin
          if (cor_sts.done) begin
            c0_r    <= cor_c;
            s0_r    <= cor_s;
            flip_r  <= nxt_ang_r[31] ^ nxt_ang_r[30];
            state_r <= S_SC1;
          end
        end
        S_SC1: begin
          if (cor_sts.done) begin
            dc_r    <= cor_c - c0_r;
            ds_r    <= cor_s - s0_r;
            state_r <= S_MUL_X;
          end
        end
        S_MUL_X: state_r <= S_MUL_Y;
        S_MUL_Y: begin
          acc_first_r <= acc_add(acc_first_r, mul_p_r);
          state_r     <= S_ACC_Y;
        end
        S_ACC_Y: begin
          acc_second_r <= acc_add(acc_second_r, mul_p_r);
          angle_now_r  <= nxt_ang_r;
          steps_left_r <= steps_left_r - 1'b1;
          stepped_r    <= 1'b1;
          state_r      <= S_OUT;
        end
        // hold until the output register is free
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tdata  <= {7'd0, stepped_r, steps_out, acc_second_r, acc_first_r};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No request is taken while an arithmetic unit is still running
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!cor_sts.busy && !div_sts.busy))
    else $error("request accepted while a unit is busy");

  // A step consumes exactly one count
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC_Y) |=> (steps_left_r == SCB'($past(steps_left_r) - 1'b1)))
    else $error("step count not decremented by one");

  // Zero radius saturates the angular step
  a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIVS) && (radius_r == 32'd0)) |=> (stp_r == 32'hFFFFFFFF))
    else $error("angular step not saturated for zero radius");
`endif

endmodule
